// ----- rtl/y2r_pkg.sv -----
package y2r_pkg;

  // Wide enough for Y*65536 plus the largest Q16 chroma product, signed.
  localparam int unsigned SUM_W = 27;

  // ITU-R coefficients, Q16, rounded to nearest
  localparam int CF_RV = 91881;
  localparam int CF_GU = 22544;
  localparam int CF_GV = 46793;
  localparam int CF_BU = 116130;
  localparam int FIX_SHIFT = 16;

  // NTSC integer coefficients
  localparam int NT_Y     = 298;
  localparam int NT_RV    = 409;
  localparam int NT_GU    = 100;
  localparam int NT_GV    = 208;
  localparam int NT_BU    = 516;
  localparam int NT_RND   = 128;
  localparam int NT_YOFS  = 16;
  localparam int NT_SHIFT = 8;

  localparam int PIX_MAX = 255;

  typedef enum logic [1:0] {
    MODE_ITU_FIXED = 2'd0,
    MODE_ITU_SHIFT = 2'd1,
    MODE_NTSC      = 2'd2
  } mode_e;

  typedef logic signed [SUM_W-1:0] sum_t;

  typedef struct packed {
    logic [7:0] luma_first;
    logic [7:0] chroma_blue;
    logic [7:0] luma_second;
    logic [7:0] chroma_red;
    logic       end_of_frame;
  } yuyv_t;

  typedef struct packed {
    logic [7:0] red_first;
    logic [7:0] green_first;
    logic [7:0] blue_first;
    logic [7:0] red_second;
    logic [7:0] green_second;
    logic [7:0] blue_second;
    logic       frame_done;
  } rgb_pair_t;

endpackage

// ----- rtl/y2r_stream_if.sv -----
interface y2r_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/yuyv_to_rgb888_converter.sv -----
// Stages: product, sum and clamp, from request accept to result valid.
// Throughput: one macropixel per cycle while the output is ready; each of the three stages holds one request
// and moves on as soon as the stage after it is free, so stalls back up stage by stage.
// Reset (rst_ni low, async): clears all stage valid bits and sets the conversion
// mode to ITU-R fixed point. Data registers are not reset.
module yuyv_to_rgb888_converter
  import y2r_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [1:0]               cfg_data_i,
  y2r_stream_if.sink               in_i,
  y2r_stream_if.source             out_o
);

  typedef struct packed {
    sum_t luma0;
    sum_t luma1;
    sum_t term_rv;
    sum_t term_gu;
    sum_t term_gv;
    sum_t term_bu;
    logic eof;
  } prod_t;

  typedef struct packed {
    sum_t r0;
    sum_t g0;
    sum_t b0;
    sum_t r1;
    sum_t g1;
    sum_t b1;
    logic eof;
  } chan_t;

  function automatic logic [7:0] clamp_pix(input sum_t s, input mode_e m);
    sum_t       sh;
    logic [7:0] res;
    unique case (m)
      MODE_ITU_SHIFT: sh = s;
      MODE_NTSC:      sh = s >>> NT_SHIFT;
      default:        sh = s >>> FIX_SHIFT;
    endcase
    priority if (s[SUM_W-1] || (s == '0)) begin
      res = '0;
    end else if (sh > sum_t'(PIX_MAX)) begin
      res = 8'(PIX_MAX);
    end else begin
      res = sh[7:0];
    end
    return res;
  endfunction

  mode_e     mode_q;
  logic      s1_v_q, s2_v_q, out_v_q;
  logic      s1_ld, s2_ld, out_ld;
  prod_t     s1_d, s1_q;
  chan_t     s2_d, s2_q;
  rgb_pair_t out_d, out_q;

  logic signed [7:0] u_s, v_s;
  sum_t              u_w, v_w, y0_w, y1_w;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_ITU_FIXED;
    end else if (cfg_we_i) begin
      mode_q <= mode_e'(cfg_data_i);
    end
  end

  // Each stage loads when empty or when its contents move on.
  assign out_ld     = !out_v_q || out_o.ready;
  assign s2_ld      = !s2_v_q || out_ld;
  assign s1_ld      = !s1_v_q || s2_ld;
  assign in_i.ready = s1_ld;

  // Cb-128 and Cr-128 as 8-bit signed: flip the top bit.
  assign u_s  = {~in_i.data.chroma_blue[7], in_i.data.chroma_blue[6:0]};
  assign v_s  = {~in_i.data.chroma_red[7], in_i.data.chroma_red[6:0]};
  assign u_w  = {{(SUM_W-8){u_s[7]}}, u_s};
  assign v_w  = {{(SUM_W-8){v_s[7]}}, v_s};
  assign y0_w = {{(SUM_W-8){1'b0}}, in_i.data.luma_first};
  assign y1_w = {{(SUM_W-8){1'b0}}, in_i.data.luma_second};

  // Stage 1: luma scaling and chroma products in the scale of the mode
  always_comb begin
    s1_d.eof = in_i.data.end_of_frame;
    unique case (mode_q)
      MODE_ITU_SHIFT: begin
        s1_d.luma0   = y0_w;
        s1_d.luma1   = y1_w;
        s1_d.term_rv = v_w + (v_w >>> 2) + (v_w >>> 3) + (v_w >>> 5);
        s1_d.term_gu = (u_w >>> 2) + (u_w >>> 4) + (u_w >>> 5);
        s1_d.term_gv = (v_w >>> 1) + (v_w >>> 3) + (v_w >>> 4) + (v_w >>> 5);
        s1_d.term_bu = u_w + (u_w >>> 1) + (u_w >>> 2) + (u_w >>> 6);
      end
      MODE_NTSC: begin
        // rounding constant folded into the luma term
        s1_d.luma0   = sum_t'(NT_Y) * (y0_w - sum_t'(NT_YOFS)) + sum_t'(NT_RND);
        s1_d.luma1   = sum_t'(NT_Y) * (y1_w - sum_t'(NT_YOFS)) + sum_t'(NT_RND);
        s1_d.term_rv = sum_t'(NT_RV) * v_w;
        s1_d.term_gu = sum_t'(NT_GU) * u_w;
        s1_d.term_gv = sum_t'(NT_GV) * v_w;
        s1_d.term_bu = sum_t'(NT_BU) * u_w;
      end
      default: begin
        // unused code 3 converts as ITU-R fixed point
        s1_d.luma0   = y0_w <<< FIX_SHIFT;
        s1_d.luma1   = y1_w <<< FIX_SHIFT;
        s1_d.term_rv = sum_t'(CF_RV) * v_w;
        s1_d.term_gu = sum_t'(CF_GU) * u_w;
        s1_d.term_gv = sum_t'(CF_GV) * v_w;
        s1_d.term_bu = sum_t'(CF_BU) * u_w;
      end
    endcase
  end

  // Stage 2: per-channel sums
  always_comb begin
    s2_d.r0  = s1_q.luma0 + s1_q.term_rv;
    s2_d.g0  = s1_q.luma0 - s1_q.term_gu - s1_q.term_gv;
    s2_d.b0  = s1_q.luma0 + s1_q.term_bu;
    s2_d.r1  = s1_q.luma1 + s1_q.term_rv;
    s2_d.g1  = s1_q.luma1 - s1_q.term_gu - s1_q.term_gv;
    s2_d.b1  = s1_q.luma1 + s1_q.term_bu;
    s2_d.eof = s1_q.eof;
  end

  // Stage 3: scale down (not in ITU-R shift mode) and clamp to 0..255
  always_comb begin
    out_d.red_first    = clamp_pix(s2_q.r0, mode_q);
    out_d.green_first  = clamp_pix(s2_q.g0, mode_q);
    out_d.blue_first   = clamp_pix(s2_q.b0, mode_q);
    out_d.red_second   = clamp_pix(s2_q.r1, mode_q);
    out_d.green_second = clamp_pix(s2_q.g1, mode_q);
    out_d.blue_second  = clamp_pix(s2_q.b1, mode_q);
    out_d.frame_done   = s2_q.eof;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (s1_ld) begin
        s1_v_q <= in_i.valid;
      end
      if (s2_ld) begin
        s2_v_q <= s1_v_q;
      end
      if (out_ld) begin
        out_v_q <= s2_v_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_ld && in_i.valid) begin
      s1_q <= s1_d;
    end
    if (s2_ld && s1_v_q) begin
      s2_q <= s2_d;
    end
    if (out_ld && s2_v_q) begin
      out_q <= out_d;
    end
  end

  assign out_o.valid = out_v_q;
  assign out_o.data  = out_q;

endmodule

// ----- rtl/y2r_checker.sv -----
module y2r_checker
  import y2r_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_ready_i,
  input  logic      out_valid_i,
  input  logic      out_ready_i,
  input  rgb_pair_t out_data_i
);

  localparam int unsigned DEPTH = 3;

  logic [2:0] occ_d, occ_q;
  logic       in_acc, out_acc;

  assign in_acc  = in_valid_i && in_ready_i;
  assign out_acc = out_valid_i && out_ready_i;
  assign occ_d   = occ_q + 3'(in_acc) - 3'(out_acc);

  // requests inside the block
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= '0;
    end else begin
      occ_q <= occ_d;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i))
    else $error("stalled result changed or dropped");

  a_capacity: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= 3'(DEPTH))
    else $error("more requests in flight than pipeline stages");

  a_room_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q < 3'(DEPTH) |-> in_ready_i)
    else $error("input stalled with a free stage");

  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> occ_q != '0)
    else $error("result without a pending request");

endmodule

bind yuyv_to_rgb888_converter y2r_checker u_y2r_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_data_i  (out_o.data)
);

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
  import y2r_pkg::*;

  localparam logic [1:0] MODE_UNUSED = 2'd3;  // decodes as ITU-R fixed point
  localparam logic [1:0] MODE_SWEEP [4] = '{MODE_ITU_FIXED, MODE_ITU_SHIFT, MODE_NTSC,
                                             MODE_UNUSED};
  localparam int RANDOM_PER_PHASE = 75;
  localparam int SINK_HOLD_CYCLES = 64;
  localparam int SETTLE_CYCLES    = 8;
  localparam int QUIET_LIMIT      = 1000;

  // ITU-R Q16 and NTSC integer coefficients
  localparam longint ITU_RV = 91881;
  localparam longint ITU_GU = 22544;
  localparam longint ITU_GV = 46793;
  localparam longint ITU_BU = 116130;
  localparam int NTSC_Y  = 298;
  localparam int NTSC_RV = 409;
  localparam int NTSC_GU = 100;
  localparam int NTSC_GV = 208;
  localparam int NTSC_BU = 516;

  typedef enum logic [1:0] {
    PACE_SLOW_SINK,
    PACE_SLOW_SOURCE,
    PACE_FULL
  } pace_e;

  logic       clk_i;
  logic       rst_ni;
  logic       cfg_we_i;
  logic [1:0] cfg_data_i;

  y2r_stream_if #(.T(yuyv_t))     yuyv_if ();
  y2r_stream_if #(.T(rgb_pair_t)) rgb_if ();

  yuyv_to_rgb888_converter dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (yuyv_if),
    .out_o      (rgb_if)
  );

  yuyv_t     pending_macropixels[$];
  rgb_pair_t expected_pixels[$];
  logic [1:0] mode_now;
  pace_e      pace;
  int         mismatches;
  int         pairs_checked;
  int         frame_ends;
  int         quiet_cycles;
  int         sink_hold_left;
  bit         sink_hold_done;

  always #6 clk_i = ~clk_i;

  function automatic logic [7:0] clip_channel(longint x);
    if (x >= 255) return 8'd255;
    if (x <= 0) return 8'd0;
    return x[7:0];
  endfunction

  function automatic logic [7:0] q16_channel(longint sum);
    if (sum <= 0) return 8'd0;
    return clip_channel(sum >>> 16);
  endfunction

  function automatic logic [23:0] pixel_rgb(logic [7:0] luma, int u, int v,
                                            logic [1:0] mode);
    longint y;
    longint yq;
    int c;
    logic [7:0] r, g, b;
    y = luma;
    case (mode)
      MODE_ITU_SHIFT: begin
        r = clip_channel(y + v + (v >>> 2) + (v >>> 3) + (v >>> 5));
        g = clip_channel(y - ((u >>> 2) + (u >>> 4) + (u >>> 5))
                         - ((v >>> 1) + (v >>> 3) + (v >>> 4) + (v >>> 5)));
        b = clip_channel(y + u + (u >>> 1) + (u >>> 2) + (u >>> 6));
      end
      MODE_NTSC: begin
        c = NTSC_Y * (int'(luma) - 16);
        r = clip_channel((c + NTSC_RV * v + 128) >>> 8);
        g = clip_channel((c - NTSC_GU * u - NTSC_GV * v + 128) >>> 8);
        b = clip_channel((c + NTSC_BU * u + 128) >>> 8);
      end
      default: begin
        yq = y * 65536;
        r = q16_channel(yq + ITU_RV * v);
        g = q16_channel(yq - ITU_GU * u - ITU_GV * v);
        b = q16_channel(yq + ITU_BU * u);
      end
    endcase
    return {r, g, b};
  endfunction

  function automatic rgb_pair_t predict_pair(yuyv_t px, logic [1:0] mode);
    rgb_pair_t res;
    int u, v;
    u = int'(px.chroma_blue) - 128;
    v = int'(px.chroma_red) - 128;
    {res.red_first, res.green_first, res.blue_first} = pixel_rgb(px.luma_first, u, v, mode);
    {res.red_second, res.green_second, res.blue_second} =
      pixel_rgb(px.luma_second, u, v, mode);
    res.frame_done = px.end_of_frame;
    return res;
  endfunction

  // mostly uniform, with the range ends and the chroma zero point weighted in
  function automatic logic [7:0] random_sample();
    case ($urandom_range(0, 9))
      0: return 8'd0;
      1: return 8'd255;
      2: return 8'd128;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic check_field(string name, logic [7:0] exp, logic [7:0] act);
    if (act !== exp) begin
      $error("%s: expected %0d, got %0d", name, exp, act);
      mismatches++;
    end
  endtask

  // wait for the pipe to drain, then write the mode register
  task automatic settle_and_set_mode(logic [1:0] mode);
    do @(negedge clk_i);
    while (pending_macropixels.size() != 0 || yuyv_if.valid || expected_pixels.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= mode;
    mode_now = mode;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // request driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (yuyv_if.valid && yuyv_if.ready) begin
        expected_pixels.push_back(predict_pair(yuyv_if.data, mode_now));
        if (yuyv_if.data.end_of_frame) frame_ends++;
      end
      if (!yuyv_if.valid || yuyv_if.ready) begin
        if (pending_macropixels.size() != 0 &&
            $urandom_range(0, 99) >= ((pace == PACE_SLOW_SINK) ? 34 :
                                      (pace == PACE_SLOW_SOURCE) ? 80 : 0)) begin
          yuyv_if.valid <= 1'b1;
          yuyv_if.data  <= pending_macropixels.pop_front();
        end else begin
          yuyv_if.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor and sink pacing
  always @(posedge clk_i) begin
    rgb_pair_t exp;
    if (rst_ni) begin
      if (rgb_if.valid && rgb_if.ready) begin
        if (expected_pixels.size() == 0) begin
          $error("result with no request outstanding");
          mismatches++;
        end else begin
          exp = expected_pixels.pop_front();
          check_field("red_first", exp.red_first, rgb_if.data.red_first);
          check_field("green_first", exp.green_first, rgb_if.data.green_first);
          check_field("blue_first", exp.blue_first, rgb_if.data.blue_first);
          check_field("red_second", exp.red_second, rgb_if.data.red_second);
          check_field("green_second", exp.green_second, rgb_if.data.green_second);
          check_field("blue_second", exp.blue_second, rgb_if.data.blue_second);
          check_field("frame_done", 8'(exp.frame_done), 8'(rgb_if.data.frame_done));
          pairs_checked++;
        end
      end
      if (sink_hold_left > 0) begin
        sink_hold_left <= sink_hold_left - 1;
        rgb_if.ready   <= 1'b0;
      end else if (pace == PACE_FULL && !sink_hold_done && pending_macropixels.size() > 40) begin
        // long back-pressure with the source still streaming
        sink_hold_left <= SINK_HOLD_CYCLES - 1;
        sink_hold_done <= 1'b1;
        rgb_if.ready   <= 1'b0;
      end else begin
        rgb_if.ready <= $urandom_range(0, 99) >= ((pace == PACE_SLOW_SINK) ? 80 :
                                                 (pace == PACE_SLOW_SOURCE) ? 34 : 0);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((yuyv_if.valid && yuyv_if.ready) || (rgb_if.valid && rgb_if.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("timeout: no request or result moved for %0d cycles", QUIET_LIMIT);
        $display("FAIL");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    yuyv_t px;
    clk_i          = 1'b0;
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_data_i     = MODE_ITU_FIXED;
    yuyv_if.valid  = 1'b0;
    yuyv_if.data   = '0;
    rgb_if.ready   = 1'b0;
    mode_now       = MODE_ITU_FIXED;
    pace           = PACE_SLOW_SINK;
    mismatches     = 0;
    pairs_checked  = 0;
    frame_ends     = 0;
    quiet_cycles   = 0;
    sink_hold_left = 0;
    sink_hold_done = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // corner pixels under every mode setting
    foreach (MODE_SWEEP[m]) begin
      settle_and_set_mode(MODE_SWEEP[m]);
      for (int k = 0; k < 6; k++) begin
        case (k)
          0: px = '{8'd0, 8'd0, 8'd0, 8'd0, 1'b0};
          1: px = '{8'd255, 8'd255, 8'd255, 8'd255, 1'b1};
          2: px = '{8'd255, 8'd0, 8'd0, 8'd255, 1'b0};
          3: px = '{8'd0, 8'd255, 8'd255, 8'd0, 1'b1};
          4: px = '{8'd16, 8'd128, 8'd235, 8'd128, 1'b0};
          default: px = '{8'd1, 8'd127, 8'd254, 8'd129, 1'b1};
        endcase
        pending_macropixels.push_back(px);
      end
    end

    for (int p = 0; p < 3; p++) begin
      for (int m = 0; m < 4; m++) begin
        settle_and_set_mode(MODE_SWEEP[(m + p) % 4]);
        pace = pace_e'(p);
        for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
          px.luma_first   = random_sample();
          px.chroma_blue  = random_sample();
          px.luma_second  = random_sample();
          px.chroma_red   = random_sample();
          px.end_of_frame = ($urandom_range(0, 15) == 0);
          pending_macropixels.push_back(px);
        end
      end
    end

    do @(negedge clk_i);
    while (pending_macropixels.size() != 0 || yuyv_if.valid || expected_pixels.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("Checked %0d pixel pairs over all four mode settings, %0d frame ends.",
             pairs_checked, frame_ends);
    $display("Traffic: both idle ratios, back-to-back streaming, one %0d-cycle output stall.",
             SINK_HOLD_CYCLES);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
